/* hw/rtl/srf_pkg.sv */
package srf_pkg;

  localparam int unsigned StepPeriodMsDef = 100;
  localparam int unsigned AluW            = 34;
  localparam int unsigned CntW            = 32;
  localparam int unsigned BandW           = 28;
  localparam int unsigned DelayW          = 8;
  localparam logic [DelayW-1:0] DelayRst  = DelayW'(1);

  typedef enum logic [1:0] {
    MODE_OFF   = 2'd0,
    MODE_MAX   = 2'd1,
    MODE_SLOPE = 2'd2,
    MODE_ON    = 2'd3
  } mode_e;

  typedef enum logic {
    REQ_SETPOINT = 1'b0,
    REQ_TICK     = 1'b1
  } req_e;

  typedef struct packed {
    logic signed [AluW-1:0] a;
    logic signed [AluW-1:0] b;
    logic                   sub;
  } alu_req_t;

  typedef struct packed {
    logic signed [AluW-1:0] sum;
    logic                   neg;
    logic                   zero;
  } alu_rsp_t;

  typedef struct packed {
    logic               valid;
    logic signed [31:0] level;
    mode_e              mode;
  } res_t;

  function automatic logic signed [AluW-1:0] ext_s24(logic signed [23:0] v);
    return {{(AluW-24){v[23]}}, v};
  endfunction

  function automatic logic signed [AluW-1:0] ext_s32(logic signed [31:0] v);
    return {{(AluW-32){v[31]}}, v};
  endfunction

endpackage

/* hw/rtl/srf_if.sv */
interface srf_in_if;
  logic               valid;
  logic               ready;
  logic               req_type;
  logic signed [23:0] setpoint;
  logic signed [23:0] actual_value;
  logic        [15:0] slope_rising;
  logic        [15:0] slope_falling;
  logic        [6:0]  elapsed_ms;

  modport source (output valid, req_type, setpoint, actual_value, slope_rising,
                  slope_falling, elapsed_ms, input ready);
  modport sink   (input valid, req_type, setpoint, actual_value, slope_rising,
                  slope_falling, elapsed_ms, output ready);
endinterface

interface srf_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] filtered_setpoint;
  logic        [1:0]  mode_code;

  modport source (output valid, filtered_setpoint, mode_code, input ready);
  modport sink   (input valid, filtered_setpoint, mode_code, output ready);
endinterface

/* hw/rtl/setpoint_ramp_filter_unit.sv */
// Channel  Dir  Handshake     Payload
// in_i     in   valid/ready   req_type, setpoint, actual_value, slope_rising,
//                             slope_falling, elapsed_ms
// out_o    out  valid/ready   filtered_setpoint, mode_code
// cfg      in   cfg_we_i      cfg_wdata_i -> delay_seconds
//
// One item at a time through a shared 34-bit add/sub unit.
// New setpoint: compare, x10, 8-step shift-add band multiply, x3, output, check;
// compare only if equal to measured value; zero or unchanged: no ALU use. Tick: ms
// add, period sub, compare, max or slope update. Result sits in an output register;
// next item is taken while it waits. rst_ni async low: mode off, delay_seconds 1.
module setpoint_ramp_filter_unit #(
  parameter int unsigned STEP_PERIOD_MS = srf_pkg::StepPeriodMsDef
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  srf_in_if.sink                     in_i,
  srf_out_if.source                  out_o,
  input  logic                       cfg_we_i,
  input  logic [srf_pkg::DelayW-1:0] cfg_wdata_i
);

  logic [srf_pkg::DelayW-1:0] delay_q;
  logic                       out_valid_q;
  logic signed [31:0]         out_level_q;
  logic [1:0]                 out_mode_q;
  logic                       res_ready;
  srf_pkg::res_t              res;

  srf_ctrl #(
    .STEP_PERIOD_MS (STEP_PERIOD_MS)
  ) u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .delay_i     (delay_q),
    .res_ready_i (res_ready),
    .res_o       (res)
  );

  assign res_ready               = !out_valid_q || out_o.ready;
  assign out_o.valid             = out_valid_q;
  assign out_o.filtered_setpoint = out_level_q;
  assign out_o.mode_code         = out_mode_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q     <= srf_pkg::DelayRst;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        delay_q <= cfg_wdata_i;
      end
      if (res.valid && res_ready) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (res.valid && res_ready) begin
      out_level_q <= res.level;
      out_mode_q  <= res.mode;
    end
  end

endmodule

/* hw/rtl/srf_alu.sv */
module srf_alu (
  input  srf_pkg::alu_req_t req_i,
  output srf_pkg::alu_rsp_t rsp_o
);

  logic signed [srf_pkg::AluW-1:0] sum;

  assign sum        = req_i.sub ? (req_i.a - req_i.b) : (req_i.a + req_i.b);
  assign rsp_o.sum  = sum;
  assign rsp_o.neg  = sum[srf_pkg::AluW-1];
  assign rsp_o.zero = (sum == '0);

endmodule

/* hw/rtl/srf_ctrl.sv */
module srf_ctrl #(
  parameter int unsigned STEP_PERIOD_MS = srf_pkg::StepPeriodMsDef
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  srf_in_if.sink                      in_i,
  input  logic [srf_pkg::DelayW-1:0]  delay_i,
  input  logic                        res_ready_i,
  output srf_pkg::res_t               res_o
);

  localparam int unsigned AluW  = srf_pkg::AluW;
  localparam int unsigned CntW  = srf_pkg::CntW;
  localparam int unsigned BandW = srf_pkg::BandW;
  localparam int unsigned IdxW  = $clog2(srf_pkg::DelayW);
  localparam logic [IdxW-1:0] IdxLast = IdxW'(srf_pkg::DelayW - 1);
  localparam logic signed [AluW-1:0] PeriodOp = AluW'(STEP_PERIOD_MS);

  typedef enum logic [14:0] {
    ST_IDLE    = 15'b000000000000001,
    ST_SP_CMP  = 15'b000000000000010,
    ST_SP_X10  = 15'b000000000000100,
    ST_SP_MUL  = 15'b000000000001000,
    ST_SP_X3   = 15'b000000000010000,
    ST_SP_OUT  = 15'b000000000100000,
    ST_SP_CHK  = 15'b000000001000000,
    ST_TK_ADD  = 15'b000000010000000,
    ST_TK_SUB  = 15'b000000100000000,
    ST_TK_CMP  = 15'b000001000000000,
    ST_MX_TRIG = 15'b000010000000000,
    ST_MX_CHK  = 15'b000100000000000,
    ST_SL_STEP = 15'b001000000000000,
    ST_SL_CHK  = 15'b010000000000000,
    ST_DONE    = 15'b100000000000000
  } state_e;

  state_e                 state_q, state_d;
  srf_pkg::mode_e         mode_q, mode_d;
  logic signed [23:0]     target_q, target_d;
  logic signed [31:0]     level_q, level_d;
  logic [15:0]            step_q, step_d;
  logic [BandW-1:0]       band_q, band_d;
  logic [CntW-1:0]        cnt_q, cnt_d;

  logic signed [23:0]     sp_q, sp_d;
  logic signed [23:0]     act_q, act_d;
  logic [15:0]            rise_q, rise_d;
  logic [15:0]            fall_q, fall_d;
  logic [6:0]             ms_q, ms_d;
  logic                   up_q, up_d;
  logic signed [AluW-1:0] acc_q, acc_d;
  logic [BandW-1:0]       mcand_q, mcand_d;
  logic [BandW-1:0]       prod_q, prod_d;
  logic [IdxW-1:0]        idx_q, idx_d;

  srf_pkg::alu_req_t      alu_req;
  srf_pkg::alu_rsp_t      alu_rsp;
  logic                   accept;

  srf_alu u_alu (
    .req_i (alu_req),
    .rsp_o (alu_rsp)
  );

  assign in_i.ready  = (state_q == ST_IDLE);
  assign accept      = in_i.valid && in_i.ready;
  assign res_o.valid = (state_q == ST_DONE);
  assign res_o.level = level_q;
  assign res_o.mode  = mode_q;

  always_comb begin
    alu_req = '0;
    unique case (state_q)
      ST_SP_CMP: begin
        alu_req.a   = srf_pkg::ext_s24(act_q);
        alu_req.b   = srf_pkg::ext_s24(sp_q);
        alu_req.sub = 1'b1;
      end
      ST_SP_X10: begin
        alu_req.a = {{(AluW-19){1'b0}}, step_q, 3'b000};
        alu_req.b = {{(AluW-17){1'b0}}, step_q, 1'b0};
      end
      ST_SP_MUL: begin
        alu_req.a = {{(AluW-BandW){1'b0}}, prod_q};
        alu_req.b = delay_i[idx_q] ? {{(AluW-BandW){1'b0}}, mcand_q} : '0;
      end
      ST_SP_X3: begin
        alu_req.a = {{(AluW-BandW-1){1'b0}}, band_q, 1'b0};
        alu_req.b = {{(AluW-BandW){1'b0}}, band_q};
      end
      ST_SP_OUT: begin
        alu_req.a   = srf_pkg::ext_s24(sp_q);
        alu_req.b   = {2'b00, acc_q[AluW-1:2]};
        alu_req.sub = up_q;
      end
      ST_SP_CHK: begin
        alu_req.a   = srf_pkg::ext_s24(act_q);
        alu_req.b   = srf_pkg::ext_s32(level_q);
        alu_req.sub = 1'b1;
      end
      ST_TK_ADD: begin
        alu_req.a = {{(AluW-CntW){1'b0}}, cnt_q};
        alu_req.b = {{(AluW-7){1'b0}}, ms_q};
      end
      ST_TK_SUB: begin
        alu_req.a   = {{(AluW-CntW){1'b0}}, cnt_q};
        alu_req.b   = PeriodOp;
        alu_req.sub = 1'b1;
      end
      ST_TK_CMP, ST_SL_CHK: begin
        alu_req.a   = srf_pkg::ext_s32(level_q);
        alu_req.b   = srf_pkg::ext_s24(target_q);
        alu_req.sub = 1'b1;
      end
      ST_MX_TRIG: begin
        alu_req.a   = srf_pkg::ext_s24(target_q);
        alu_req.b   = {{(AluW-BandW){1'b0}}, band_q};
        alu_req.sub = up_q;
      end
      ST_MX_CHK: begin
        alu_req.a   = srf_pkg::ext_s24(act_q);
        alu_req.b   = acc_q;
        alu_req.sub = 1'b1;
      end
      ST_SL_STEP: begin
        alu_req.a   = srf_pkg::ext_s32(level_q);
        alu_req.b   = {{(AluW-16){1'b0}}, step_q};
        alu_req.sub = !up_q;
      end
      default: alu_req = '0;
    endcase
  end

  always_comb begin
    state_d  = state_q;
    mode_d   = mode_q;
    target_d = target_q;
    level_d  = level_q;
    step_d   = step_q;
    band_d   = band_q;
    cnt_d    = cnt_q;
    sp_d     = sp_q;
    act_d    = act_q;
    rise_d   = rise_q;
    fall_d   = fall_q;
    ms_d     = ms_q;
    up_d     = up_q;
    acc_d    = acc_q;
    mcand_d  = mcand_q;
    prod_d   = prod_q;
    idx_d    = idx_q;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          sp_d   = in_i.setpoint;
          act_d  = in_i.actual_value;
          rise_d = in_i.slope_rising;
          fall_d = in_i.slope_falling;
          ms_d   = in_i.elapsed_ms;
          if (in_i.req_type == srf_pkg::REQ_TICK) begin
            state_d = ST_TK_ADD;
          end else if (in_i.setpoint == '0) begin
            target_d = '0;
            level_d  = '0;
            mode_d   = srf_pkg::MODE_OFF;
            state_d  = ST_DONE;
          end else if (mode_q != srf_pkg::MODE_OFF && target_q == in_i.setpoint) begin
            state_d = ST_DONE;
          end else begin
            target_d = in_i.setpoint;
            mode_d   = srf_pkg::MODE_MAX;
            state_d  = ST_SP_CMP;
          end
        end
      end
      ST_SP_CMP: begin
        if (alu_rsp.zero) begin
          level_d = 32'(signed'(target_q));
          mode_d  = srf_pkg::MODE_ON;
          state_d = ST_DONE;
        end else begin
          up_d    = alu_rsp.neg;
          step_d  = alu_rsp.neg ? rise_q : fall_q;
          state_d = ST_SP_X10;
        end
      end
      ST_SP_X10: begin
        mcand_d = alu_rsp.sum[BandW-1:0];
        prod_d  = '0;
        idx_d   = '0;
        state_d = ST_SP_MUL;
      end
      ST_SP_MUL: begin
        prod_d  = alu_rsp.sum[BandW-1:0];
        mcand_d = {mcand_q[BandW-2:0], 1'b0};
        idx_d   = idx_q + 1'b1;
        if (idx_q == IdxLast) begin
          band_d  = alu_rsp.sum[BandW-1:0];
          state_d = ST_SP_X3;
        end
      end
      ST_SP_X3: begin
        acc_d   = alu_rsp.sum;
        state_d = ST_SP_OUT;
      end
      ST_SP_OUT: begin
        level_d = alu_rsp.sum[31:0];
        state_d = ST_SP_CHK;
      end
      ST_SP_CHK: begin
        if (up_q ? (!alu_rsp.neg && !alu_rsp.zero) : alu_rsp.neg) begin
          level_d = 32'(signed'(act_q));
          mode_d  = srf_pkg::MODE_SLOPE;
        end
        state_d = ST_DONE;
      end
      ST_TK_ADD: begin
        cnt_d   = alu_rsp.sum[CntW-1:0];
        state_d = ST_TK_SUB;
      end
      ST_TK_SUB: begin
        if (alu_rsp.neg) begin
          state_d = ST_DONE;
        end else begin
          cnt_d = alu_rsp.sum[CntW-1:0];
          if (mode_q == srf_pkg::MODE_MAX || mode_q == srf_pkg::MODE_SLOPE) begin
            state_d = ST_TK_CMP;
          end else begin
            state_d = ST_DONE;
          end
        end
      end
      ST_TK_CMP: begin
        if (alu_rsp.zero) begin
          mode_d  = srf_pkg::MODE_ON;
          state_d = ST_DONE;
        end else begin
          up_d    = alu_rsp.neg;
          state_d = (mode_q == srf_pkg::MODE_MAX) ? ST_MX_TRIG : ST_SL_STEP;
        end
      end
      ST_MX_TRIG: begin
        acc_d   = alu_rsp.sum;
        state_d = ST_MX_CHK;
      end
      ST_MX_CHK: begin
        if (up_q ? (!alu_rsp.neg && !alu_rsp.zero) : alu_rsp.neg) begin
          mode_d = srf_pkg::MODE_SLOPE;
        end
        state_d = ST_DONE;
      end
      ST_SL_STEP: begin
        level_d = alu_rsp.sum[31:0];
        state_d = ST_SL_CHK;
      end
      ST_SL_CHK: begin
        if (up_q ? (!alu_rsp.neg && !alu_rsp.zero) : alu_rsp.neg) begin
          level_d = 32'(signed'(target_q));
          mode_d  = srf_pkg::MODE_ON;
        end
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (res_ready_i) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      mode_q   <= srf_pkg::MODE_OFF;
      target_q <= '0;
      level_q  <= '0;
      step_q   <= '0;
      band_q   <= '0;
      cnt_q    <= '0;
    end else begin
      state_q  <= state_d;
      mode_q   <= mode_d;
      target_q <= target_d;
      level_q  <= level_d;
      step_q   <= step_d;
      band_q   <= band_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    sp_q    <= sp_d;
    act_q   <= act_d;
    rise_q  <= rise_d;
    fall_q  <= fall_d;
    ms_q    <= ms_d;
    up_q    <= up_d;
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    prod_q  <= prod_d;
    idx_q   <= idx_d;
  end

  a_off_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == srf_pkg::MODE_OFF |-> level_q == '0 && target_q == '0)
    else $error("off mode with nonzero level or target");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q != ST_IDLE)
    else $error("accepted item did not start");

  a_cnt_only_on_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q != ST_TK_ADD && state_q != ST_TK_SUB |=> $stable(cnt_q))
    else $error("ms accumulator changed outside tick handling");

  a_done_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_DONE && !res_ready_i |=> state_q == ST_DONE && $stable(level_q))
    else $error("result dropped while stalled");

endmodule

/* tb/tb_setpoint_ramp_filter_unit.sv */
`timescale 1ns / 100ps

module tb_setpoint_ramp_filter_unit;

  localparam int    CycLimit = 1_000_000;
  localparam int    DlyW     = srf_pkg::DelayW;
  localparam longint MaxS24  = 8388607;
  localparam longint MinS24  = -8388608;

  typedef struct {
    srf_pkg::req_e      kind;
    logic signed [23:0] sp;
    logic signed [23:0] act;
    logic        [15:0] rise;
    logic        [15:0] fall;
    logic        [6:0]  ms;
    bit                 fixed;
    logic signed [31:0] e_lvl;
    srf_pkg::mode_e     e_mode;
  } stim_t;

  typedef struct {
    logic signed [31:0] lvl;
    srf_pkg::mode_e     mode;
  } lvl_mode_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [DlyW-1:0] cfg_wdata_i = '0;

  srf_in_if  in_ch ();
  srf_out_if out_ch ();

  setpoint_ramp_filter_unit i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_ch),
    .out_o       (out_ch),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  always #4 clk_i = ~clk_i;

  // filter state as seen from outside
  srf_pkg::mode_e m_mode   = srf_pkg::MODE_OFF;
  int             m_target = 0;
  int             m_level  = 0;
  int unsigned    m_step   = 0;
  int unsigned    m_band   = 0;
  int unsigned    m_acc    = 0;
  int unsigned    m_delay  = 32'(srf_pkg::DelayRst);

  lvl_mode_t pending_out[$];
  stim_t     drv_row;
  stim_t     dir_rows[$];
  int        errs      = 0;
  int        cyc       = 0;
  int        sink_wait = 0;
  bit        calm      = 1'b0;

  function automatic void ramp_update(input stim_t s);
    longint q3;
    int     sp;
    int     act;
    act = int'(s.act);
    if (s.kind == srf_pkg::REQ_SETPOINT) begin
      sp = int'(s.sp);
      if (sp == 0) begin
        m_target = 0;
        m_level  = 0;
        m_mode   = srf_pkg::MODE_OFF;
      end else if (m_mode == srf_pkg::MODE_OFF || m_target != sp) begin
        m_target = sp;
        m_mode   = srf_pkg::MODE_MAX;
        if (act < sp) begin
          m_step  = 32'(s.rise);
          m_band  = m_step * 10 * m_delay;
          q3      = (longint'(m_band) * 3) / 4;
          m_level = int'(longint'(sp) - q3);
          if (act > m_level) begin
            m_level = act;
            m_mode  = srf_pkg::MODE_SLOPE;
          end
        end else if (act > sp) begin
          m_step  = 32'(s.fall);
          m_band  = m_step * 10 * m_delay;
          q3      = (longint'(m_band) * 3) / 4;
          m_level = int'(longint'(sp) + q3);
          if (act < m_level) begin
            m_level = act;
            m_mode  = srf_pkg::MODE_SLOPE;
          end
        end else begin
          m_level = sp;
          m_mode  = srf_pkg::MODE_ON;
        end
      end
    end else begin
      m_acc += 32'(s.ms);
      if (m_acc >= srf_pkg::StepPeriodMsDef) begin
        m_acc -= srf_pkg::StepPeriodMsDef;
        case (m_mode)
          srf_pkg::MODE_MAX: begin
            if (m_level < m_target) begin
              if (longint'(act) > longint'(m_target) - longint'(m_band))
                m_mode = srf_pkg::MODE_SLOPE;
            end else if (m_level > m_target) begin
              if (longint'(act) < longint'(m_target) + longint'(m_band))
                m_mode = srf_pkg::MODE_SLOPE;
            end else begin
              m_mode = srf_pkg::MODE_ON;
            end
          end
          srf_pkg::MODE_SLOPE: begin
            if (m_level < m_target) begin
              m_level = int'(longint'(m_level) + longint'(m_step));
              if (m_level > m_target) begin
                m_level = m_target;
                m_mode  = srf_pkg::MODE_ON;
              end
            end else if (m_level > m_target) begin
              m_level = int'(longint'(m_level) - longint'(m_step));
              if (m_level < m_target) begin
                m_level = m_target;
                m_mode  = srf_pkg::MODE_ON;
              end
            end else begin
              m_mode = srf_pkg::MODE_ON;
            end
          end
          default: ;
        endcase
      end
    end
  endfunction

  function automatic stim_t mk(srf_pkg::req_e k, int sp, int act, int rise, int fall, int ms,
                               bit fx, int lvl, srf_pkg::mode_e md);
    stim_t s;
    s.kind   = k;
    s.sp     = 24'(sp);
    s.act    = 24'(act);
    s.rise   = 16'(rise);
    s.fall   = 16'(fall);
    s.ms     = 7'(ms);
    s.fixed  = fx;
    s.e_lvl  = lvl;
    s.e_mode = md;
    return s;
  endfunction

  function automatic logic signed [23:0] clip24(longint v);
    if (v > MaxS24) return 24'(MaxS24);
    if (v < MinS24) return 24'(MinS24);
    return 24'(v);
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [15:0] pick_slope();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 16'd0;
    if (r == 1) return 16'($urandom_range(0, 65535));
    return 16'($urandom_range(1, 300));
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send(input stim_t s);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    drv_row               <= s;
    in_ch.req_type        <= s.kind;
    in_ch.setpoint        <= s.sp;
    in_ch.actual_value    <= s.act;
    in_ch.slope_rising    <= s.rise;
    in_ch.slope_falling   <= s.fall;
    in_ch.elapsed_ms      <= s.ms;
    in_ch.valid           <= 1'b1;
    do @(posedge clk_i); while (!in_ch.ready);
    @(negedge clk_i);
  endtask

  task automatic hold_until_drained();
    in_ch.valid <= 1'b0;
    @(negedge clk_i);
    while (pending_out.size() != 0) @(negedge clk_i);
  endtask

  task automatic write_delay(input logic [DlyW-1:0] v);
    hold_until_drained();
    repeat (4) @(negedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(negedge clk_i);
    cfg_we_i    <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic run_phase(input int n_items);
    int     done;
    int     n_ticks;
    longint sp;
    longint act;
    longint band;
    stim_t  s;
    done = 0;
    while (done < n_items) begin
      s.kind   = srf_pkg::REQ_SETPOINT;
      s.fixed  = 1'b0;
      s.e_lvl  = '0;
      s.e_mode = srf_pkg::MODE_OFF;
      s.ms     = 7'($urandom);
      s.rise   = pick_slope();
      s.fall   = pick_slope();
      case ($urandom_range(0, 15))
        0:       sp = 0;
        1:       sp = longint'(m_target);
        2, 3:    sp = longint'($signed(24'($urandom)));
        default: sp = longint'($urandom_range(0, 200000)) - 100000;
      endcase
      s.sp = clip24(sp);
      sp   = longint'(s.sp);
      band = longint'(s.rise > s.fall ? s.rise : s.fall) * 10 * longint'(m_delay) + 1;
      case ($urandom_range(0, 9))
        0:       act = sp;
        1:       act = longint'($signed(24'($urandom)));
        2, 3, 4: act = sp - longint'($urandom_range(0, 32'(band)));
        5, 6, 7: act = sp + longint'($urandom_range(0, 32'(band)));
        default: act = sp + longint'($urandom_range(0, 32'(4 * band))) - 2 * band;
      endcase
      s.act = clip24(act);
      send(s);
      done++;

      n_ticks = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 30);
      repeat (n_ticks) begin
        s.kind = srf_pkg::REQ_TICK;
        s.sp   = 24'($urandom);
        s.rise = 16'($urandom);
        s.fall = 16'($urandom);
        case ($urandom_range(0, 9))
          0, 1, 2: s.ms = 7'($urandom_range(0, 100));
          3:       s.ms = 7'($urandom_range(101, 127));
          default: s.ms = 7'(srf_pkg::StepPeriodMsDef);
        endcase
        if ($urandom_range(0, 3) == 0)
          s.act = 24'($urandom);
        else
          s.act = clip24(longint'(m_target) + longint'($urandom_range(0, 32'(2 * band)))
                         - band);
        send(s);
        done++;
      end
      if ($urandom_range(0, 60) == 0) hold_until_drained();
    end
  endtask

  always @(posedge clk_i) begin : model_in
    lvl_mode_t r;
    if (rst_ni) begin
      if (cfg_we_i) m_delay = 32'(cfg_wdata_i);
      if (in_ch.valid && in_ch.ready) begin
        ramp_update(drv_row);
        if (drv_row.fixed) begin
          r.lvl  = drv_row.e_lvl;
          r.mode = drv_row.e_mode;
        end else begin
          r.lvl  = m_level;
          r.mode = m_mode;
        end
        pending_out.push_back(r);
      end
    end
  end

  always @(posedge clk_i) begin : chk_out
    lvl_mode_t e;
    if (rst_ni && out_ch.valid && out_ch.ready) begin
      if (pending_out.size() == 0) begin
        $error("unexpected item: filtered_setpoint %0d mode_code %0d",
               out_ch.filtered_setpoint, out_ch.mode_code);
        errs++;
      end else begin
        e = pending_out.pop_front();
        if (out_ch.filtered_setpoint !== e.lvl) begin
          $error("filtered_setpoint: expected %0d, got %0d", e.lvl, out_ch.filtered_setpoint);
          errs++;
        end
        if (out_ch.mode_code !== e.mode) begin
          $error("mode_code: expected %0d, got %0d", e.mode, out_ch.mode_code);
          errs++;
        end
      end
    end
  end

  always @(negedge clk_i) begin
    if (sink_wait > 0) begin
      out_ch.ready <= 1'b0;
      sink_wait--;
    end else begin
      out_ch.ready <= 1'b1;
      if ($urandom_range(0, 2) == 0) sink_wait = pick_gap();
    end
  end

  always @(posedge clk_i) begin
    cyc++;
    if ($urandom_range(0, 299) == 0) calm = !calm;
    if (cyc > CycLimit) begin
      $display("** setpoint_ramp_filter_unit: FAILED **");
      $finish;
    end
  end

  initial begin
    in_ch.valid         = 1'b0;
    in_ch.req_type      = srf_pkg::REQ_SETPOINT;
    in_ch.setpoint      = '0;
    in_ch.actual_value  = '0;
    in_ch.slope_rising  = '0;
    in_ch.slope_falling = '0;
    in_ch.elapsed_ms    = '0;
    out_ch.ready        = 1'b0;

    dir_rows = {
      mk(srf_pkg::REQ_TICK,     0,        0,        0,     0,     0,   1, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_SETPOINT, 0,        5,        3,     3,     0,   1, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_SETPOINT, 100,      100,      9,     9,     0,   1, 100,
         srf_pkg::MODE_ON),
      mk(srf_pkg::REQ_SETPOINT, 100,      -3,       7,     7,     0,   1, 100,
         srf_pkg::MODE_ON),
      mk(srf_pkg::REQ_TICK,     0,        0,        0,     0,     127, 1, 100,
         srf_pkg::MODE_ON),
      mk(srf_pkg::REQ_SETPOINT, 8388607,  -8388608, 65535, 0,     0,   0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        0,        0,     0,     100, 0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        8000000,  0,     0,     100, 0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        8000000,  0,     0,     100, 0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        8100000,  0,     0,     127, 0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_SETPOINT, -8388608, 8388607,  0,     65535, 0,   0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        -8000000, 0,     0,     100, 0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        -8000000, 0,     0,     100, 0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_SETPOINT, 1000,     500,      0,     0,     0,   0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        999,      0,     0,     100, 0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_SETPOINT, 0,        -1,       1,     1,     0,   1, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_SETPOINT, -1,       0,        65535, 1,     0,   0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        0,        0,     0,     50,  0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        0,        0,     0,     50,  0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        0,        0,     0,     100, 0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_SETPOINT, 1,        0,        1,     65535, 0,   0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        0,        0,     0,     100, 0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_TICK,     0,        0,        0,     0,     100, 0, 0,
         srf_pkg::MODE_OFF),
      mk(srf_pkg::REQ_SETPOINT, 0,        77,       5,     5,     0,   1, 0,
         srf_pkg::MODE_OFF)
    };

    repeat (7) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) send(dir_rows[i]);

    write_delay(8'd0);
    run_phase(280);
    write_delay(8'd255);
    run_phase(280);
    write_delay(8'd3);
    run_phase(280);
    write_delay(DlyW'($urandom_range(2, 254)));
    run_phase(280);
    write_delay(8'd1);
    run_phase(280);

    hold_until_drained();
    repeat (30) @(posedge clk_i);
    if (errs == 0) begin
      $display("** setpoint_ramp_filter_unit: PASSED **");
    end else begin
      $display("** setpoint_ramp_filter_unit: FAILED **");
    end
    $finish;
  end

endmodule
